FILE: design/f16l2_pkg.sv
// Shared types, constants and floating-point helpers for the fp16 squared distance block.
package f16l2_pkg;

    localparam int LANES     = 4;
    localparam int ELEM_W    = 16;
    localparam int COUNT_W   = 3;
    localparam int S_TDATA_W = 136;
    localparam int M_TDATA_W = 32;

    localparam logic [31:0] FP32_QNAN = 32'h7FC0_0000;
    localparam logic [31:0] FP32_INF  = 32'h7F80_0000;
    localparam logic [31:0] FP32_ZERO = 32'h0000_0000;

    // aligned magnitude sum or difference of two fp16 values, before rounding
    typedef struct packed {
        logic        nan;
        logic        inf;
        logic [4:0]  exp;
        logic [14:0] mag;
    } f16l2_dif_t;

    // rounded fp16 magnitude: value = man * 2^(exp - 25), exp never below one
    typedef struct packed {
        logic        nan;
        logic        inf;
        logic [4:0]  exp;
        logic [10:0] man;
    } f16l2_rnd_t;

    // pipeline enables and the accumulator clear, shared by all lanes
    typedef struct packed {
        logic p1_en;
        logic p2_en;
        logic p3_en;
        logic acc_en;
        logic acc_clr;
    } f16l2_lane_ctl_t;

    // align and add or subtract magnitudes of x and y; the sign of x - y is not needed
    function automatic f16l2_dif_t f16l2_diff(input logic [15:0] x, input logic [15:0] y);
        f16l2_dif_t  res;
        logic        xinf, yinf, xnan, ynan, sub;
        logic [14:0] big, sml;
        logic [4:0]  eb, es, d;
        logic [3:0]  sh;
        logic [10:0] mb, ms;
        logic [27:0] al;
        logic [13:0] wa, wb;
        xinf = (&x[14:10]) & ~(|x[9:0]);
        yinf = (&y[14:10]) & ~(|y[9:0]);
        xnan = (&x[14:10]) & (|x[9:0]);
        ynan = (&y[14:10]) & (|y[9:0]);
        sub  = (x[15] == y[15]);
        if (x[14:0] >= y[14:0]) begin
            big = x[14:0];
            sml = y[14:0];
        end else begin
            big = y[14:0];
            sml = x[14:0];
        end
        eb = (big[14:10] == 5'd0) ? 5'd1 : big[14:10];
        es = (sml[14:10] == 5'd0) ? 5'd1 : sml[14:10];
        mb = {|big[14:10], big[9:0]};
        ms = {|sml[14:10], sml[9:0]};
        d  = eb - es;
        sh = (d > 5'd15) ? 4'd15 : d[3:0];
        al = {ms, 3'b000, 14'd0} >> sh;
        wa = {mb, 3'b000};
        wb = {al[27:15], al[14] | (|al[13:0])};
        res.nan = xnan | ynan | (xinf & yinf & sub);
        res.inf = ~res.nan & (xinf | yinf);
        res.exp = eb;
        res.mag = sub ? ({1'b0, wa} - {1'b0, wb}) : ({1'b0, wa} + {1'b0, wb});
        return res;
    endfunction

    // normalise and round to nearest even at fp16 precision
    function automatic f16l2_rnd_t f16l2_norm(input f16l2_dif_t d);
        f16l2_rnd_t  res;
        logic [3:0]  lz, lim, sh;
        logic [13:0] n;
        logic [5:0]  e;
        logic        up;
        logic [11:0] mr;
        lz = 4'd14;
        for (int i = 0; i < 14; i++) begin
            if (d.mag[i]) lz = 4'(13 - i);
        end
        lim = 4'(d.exp - 5'd1 > 5'd14 ? 5'd14 : d.exp - 5'd1);
        sh  = (lz < lim) ? lz : lim;
        if (d.mag[14]) begin
            n = {d.mag[14:2], d.mag[1] | d.mag[0]};
            e = {1'b0, d.exp} + 6'd1;
        end else begin
            n = d.mag[13:0] << sh;
            e = {1'b0, d.exp} - {2'b00, sh};
        end
        up = n[2] & (n[1] | n[0] | n[3]);
        mr = {1'b0, n[13:3]} + {11'd0, up};
        if (mr[11]) begin
            res.man = 11'h400;
            e       = e + 6'd1;
        end else begin
            res.man = mr[10:0];
        end
        res.nan = d.nan;
        res.inf = ~d.nan & (d.inf | (e >= 6'd31));
        res.exp = e[4:0];
        return res;
    endfunction

    // exact square of a rounded fp16 magnitude as fp32 bits; inactive lanes give +0
    function automatic logic [31:0] f16l2_square(input f16l2_rnd_t r, input logic act);
        logic [31:0] res;
        logic [3:0]  lz;
        logic [10:0] mn;
        logic [21:0] mm;
        logic [8:0]  ex, ex1;
        lz = 4'd0;
        for (int i = 0; i < 11; i++) begin
            if (r.man[i]) lz = 4'(10 - i);
        end
        mn  = r.man << lz;
        mm  = {11'd0, mn} * {11'd0, mn};
        ex  = {3'b000, r.exp, 1'b0} + 9'd98 - {4'b0000, lz, 1'b0};
        ex1 = ex - 9'd1;
        if (!act) begin
            res = FP32_ZERO;
        end else if (r.nan) begin
            res = FP32_QNAN;
        end else if (r.inf) begin
            res = FP32_INF;
        end else if (r.man == 11'd0) begin
            res = FP32_ZERO;
        end else if (mm[21]) begin
            res = {1'b0, ex[7:0], mm[20:0], 2'b00};
        end else begin
            res = {1'b0, ex1[7:0], mm[19:0], 3'b000};
        end
        return res;
    endfunction

    // fp32 add, round to nearest even, for operands known to be non-negative
    function automatic logic [31:0] f16l2_add(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] res, big, sml;
        logic        anan, bnan, ainf, binf;
        logic [7:0]  eb, es, d;
        logic [4:0]  sh;
        logic [23:0] mb, ms, m;
        logic [53:0] al;
        logic [26:0] wa, wb, n;
        logic [27:0] s;
        logic [8:0]  e;
        logic        up;
        logic [24:0] mr;
        anan = (&a[30:23]) & (|a[22:0]);
        bnan = (&b[30:23]) & (|b[22:0]);
        ainf = (&a[30:23]) & ~(|a[22:0]);
        binf = (&b[30:23]) & ~(|b[22:0]);
        if (a[30:0] >= b[30:0]) begin
            big = a;
            sml = b;
        end else begin
            big = b;
            sml = a;
        end
        eb = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        es = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
        mb = {|big[30:23], big[22:0]};
        ms = {|sml[30:23], sml[22:0]};
        d  = eb - es;
        sh = (d > 8'd28) ? 5'd28 : d[4:0];
        al = {ms, 3'b000, 27'd0} >> sh;
        wa = {mb, 3'b000};
        wb = {al[53:28], al[27] | (|al[26:0])};
        s  = {1'b0, wa} + {1'b0, wb};
        if (s[27]) begin
            n = {s[27:2], s[1] | s[0]};
            e = {1'b0, eb} + 9'd1;
        end else begin
            n = s[26:0];
            e = {1'b0, eb};
        end
        up = n[2] & (n[1] | n[0] | n[3]);
        mr = {1'b0, n[26:3]} + {24'd0, up};
        if (mr[24]) begin
            m = 24'h80_0000;
            e = e + 9'd1;
        end else begin
            m = mr[23:0];
        end
        if (anan | bnan) begin
            res = FP32_QNAN;
        end else if (ainf | binf | (e >= 9'd255)) begin
            res = FP32_INF;
        end else begin
            res = {1'b0, m[23] ? e[7:0] : 8'd0, m[22:0]};
        end
        return res;
    endfunction

endpackage

FILE: design/fp16_squared_l2_distance.sv
// Top level of the fp16 squared L2 distance block: input control, four lanes, merge.
//
//   channel  dir  payload                                  marks end
//   s_       in   x0..x3, y0..y3 fp16, valid_count          s_tlast
//   m_       out  fp32 squared distance                     -
//
// One word is taken every cycle unless a frame end waits on full merge stages. The
// sum of a frame passes three lane stages, the combinational fp32 add in each lane's
// accumulator loop and three merge stages before it leaves. Reset clears all lane sums to +0.
// A stalled output holds the merge stages; the lanes keep going until a fourth
// frame end finds all three merge stages full.
module fp16_squared_l2_distance (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // x_elem0..3 [63:0], y_elem0..3 [127:64], valid_count [130:128], zeros above
    input  logic [f16l2_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // distance [31:0]
    output logic [f16l2_pkg::M_TDATA_W-1:0]  m_tdata
);
    import f16l2_pkg::*;

    logic                   v1_reg, v2_reg, v3_reg;
    logic                   last1_reg, last2_reg, last3_reg;
    logic                   r1, r2, r3, acc_fire, load_ready;
    logic [COUNT_W-1:0]     vcount;
    f16l2_lane_ctl_t        ctl;
    logic [LANES-1:0][31:0] totals;

    assign vcount   = s_tdata[2*LANES*ELEM_W +: COUNT_W];
    assign acc_fire = v3_reg & (~last3_reg | load_ready);
    assign r3       = ~v3_reg | acc_fire;
    assign r2       = ~v2_reg | r3;
    assign r1       = ~v1_reg | r2;
    assign s_tready = r1;

    assign ctl = '{p1_en:   s_tvalid & r1,
                   p2_en:   v1_reg & r2,
                   p3_en:   v2_reg & r3,
                   acc_en:  acc_fire,
                   acc_clr: last3_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (r1) v1_reg <= s_tvalid;
            if (r2) v2_reg <= v1_reg;
            if (r3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.p1_en) last1_reg <= s_tlast;
        if (ctl.p2_en) last2_reg <= last1_reg;
        if (ctl.p3_en) last3_reg <= last2_reg;
    end

    for (genvar i = 0; i < LANES; i++) begin : g_lane
        f16l2_lane u_lane (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctl        (ctl),
            .x_elem     (s_tdata[i*ELEM_W +: ELEM_W]),
            .y_elem     (s_tdata[(LANES+i)*ELEM_W +: ELEM_W]),
            .act        (vcount > COUNT_W'(i)),
            .lane_total (totals[i])
        );
    end

    f16l2_merge u_merge (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (acc_fire & last3_reg),
        .totals     (totals),
        .load_ready (load_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

FILE: design/f16l2_lane.sv
// One lane: fp16 difference, rounding, exact square and fp32 running sum.
module f16l2_lane (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  f16l2_pkg::f16l2_lane_ctl_t ctl,
    input  logic [15:0]               x_elem,
    input  logic [15:0]               y_elem,
    input  logic                      act,
    output logic [31:0]               lane_total
);
    import f16l2_pkg::*;

    f16l2_dif_t  dif_reg;
    f16l2_rnd_t  rnd_reg;
    logic        act1_reg, act2_reg;
    logic [31:0] sq_reg;
    logic [31:0] sum_reg;

    assign lane_total = f16l2_add(sum_reg, sq_reg);

    always_ff @(posedge aclk) begin
        if (ctl.p1_en) begin
            dif_reg  <= f16l2_diff(x_elem, y_elem);
            act1_reg <= act;
        end
        if (ctl.p2_en) begin
            rnd_reg  <= f16l2_norm(dif_reg);
            act2_reg <= act1_reg;
        end
        if (ctl.p3_en) begin
            sq_reg <= f16l2_square(rnd_reg, act2_reg);
        end
    end

    // clear once the frame total has been handed to the merge stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= FP32_ZERO;
        end else if (ctl.acc_en) begin
            sum_reg <= ctl.acc_clr ? FP32_ZERO : lane_total;
        end
    end

endmodule

FILE: design/f16l2_merge.sv
// Merge stage: pairwise fp32 tree over the lane totals and the output register.
module f16l2_merge (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 load,
    input  logic [f16l2_pkg::LANES-1:0][31:0]    totals,
    output logic                                 load_ready,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [31:0]                          m_tdata
);
    import f16l2_pkg::*;

    logic [LANES-1:0][31:0] t1_reg;
    logic [31:0]            s01_reg, s23_reg, dist_reg;
    logic                   t1_v_reg, t2_v_reg, out_v_reg;
    logic                   out_ready, t2_ready;

    assign out_ready  = ~out_v_reg | m_tready;
    assign t2_ready   = ~t2_v_reg | out_ready;
    assign load_ready = ~t1_v_reg | t2_ready;
    assign m_tvalid   = out_v_reg;
    assign m_tdata    = dist_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t1_v_reg  <= 1'b0;
            t2_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end else begin
            if (load_ready) t1_v_reg  <= load;
            if (t2_ready)   t2_v_reg  <= t1_v_reg;
            if (out_ready)  out_v_reg <= t2_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (load & load_ready) begin
            t1_reg <= totals;
        end
        if (t1_v_reg & t2_ready) begin
            s01_reg <= f16l2_add(t1_reg[0], t1_reg[1]);
            s23_reg <= f16l2_add(t1_reg[2], t1_reg[3]);
        end
        if (t2_v_reg & out_ready) begin
            dist_reg <= f16l2_add(s01_reg, s23_reg);
        end
    end

endmodule
